// ----- rtl/tt_pkg.sv -----
// package for the text terminal character engine
// screen geometry, character codes, fsm states, register map and address helpers
// no dependencies
`default_nettype none

package tt_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  // port field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int WORD_W = 16;

  // internal widths
  localparam int CNT_W  = $clog2(COLS);
  localparam int TOP_W  = $clog2(ROWS);
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [WORD_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  // apb register map
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTR = '0;

  typedef enum logic {
    ACT_PUT  = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_BSCAN,
    ST_DONE
  } state_t;

  function automatic logic [TOP_W-1:0] row_inc(input logic [TOP_W-1:0] r);
    row_inc = (r == TOP_W'(ROWS - 1)) ? '0 : r + 1'b1;
  endfunction

  function automatic logic [TOP_W-1:0] row_dec(input logic [TOP_W-1:0] r);
    row_dec = (r == '0) ? TOP_W'(ROWS - 1) : r - 1'b1;
  endfunction

  // logical row to physical row of the circular row buffer
  function automatic logic [TOP_W-1:0] phys_row(input logic [TOP_W-1:0] top,
                                                input logic [TOP_W-1:0] lrow);
    logic [TOP_W:0] sum;
    sum = {1'b0, top} + {1'b0, lrow};
    if (sum >= (TOP_W + 1)'(ROWS)) begin
      sum = sum - (TOP_W + 1)'(ROWS);
    end
    phys_row = sum[TOP_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [TOP_W-1:0] row,
                                                  input logic [CNT_W-1:0] col);
    cell_addr = ADDR_W'(int'(row) * COLS + int'(col));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tt_ifs.sv -----
// valid/ready channel interfaces for the item and result transfers
// depends on tt_pkg
`default_nettype none

interface tt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [tt_pkg::CHAR_W-1:0] char_code;
  logic [tt_pkg::ROW_W-1:0]  read_row;
  logic [tt_pkg::COL_W-1:0]  read_col;

  modport source (output valid, action, char_code, read_row, read_col, input ready);
  modport sink   (input valid, action, char_code, read_row, read_col, output ready);
endinterface

interface tt_out_if;
  logic                      valid;
  logic                      ready;
  logic [tt_pkg::WORD_W-1:0] cell_word;
  logic [tt_pkg::COL_W-1:0]  cursor_column;
  logic [tt_pkg::ROW_W-1:0]  cursor_line;

  modport source (output valid, cell_word, cursor_column, cursor_line, input ready);
  modport sink   (input valid, cell_word, cursor_column, cursor_line, output ready);
endinterface

`default_nettype wire

// ----- rtl/tt_ram.sv -----
// simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module tt_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tt_apb_regs.sv -----
// apb configuration register: text attribute
// depends on tt_pkg
`default_nettype none

module tt_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tt_pkg::PADDR_W-1:0] paddr,
  input  logic [tt_pkg::PDATA_W-1:0] pwdata,
  output logic [tt_pkg::PDATA_W-1:0] prdata,
  output logic                       pready,
  output logic [tt_pkg::ATTR_W-1:0]  text_attribute
);
  import tt_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (wr_en && (reg_idx == REG_TEXT_ATTR)) begin
      text_attribute <= pwdata[ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_TEXT_ATTR) begin
      prdata = PDATA_W'(text_attribute);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/text_terminal_char_engine.sv -----
// text terminal character engine: put a character on the bottom row or read a cell
// Channels: in_ch carries one item (action, char_code, read_row, read_col), out_ch
// returns exactly one result per item (cell_word, cursor_column, cursor_line).
// An APB port writes the text attribute used for new characters and blanks.
// The screen lives in one ROWS*COLS cell memory organized as a circular row
// buffer, so a scroll only moves the top-row pointer and blanks one row.
// A newline or right-edge wrap blanks one row, one cell a cycle; a backspace at
// column 0 blanks a row while the new bottom row is scanned for the last text,
// in parallel.
// One item is in work at a time; the next item is taken when the result has
// moved into the output register, even if the receiver has not taken it yet.
// After reset the memory is cleared to spaces with attribute 0x07, one cell a
// cycle over all ROWS*COLS (2000) cells; no item is taken during that pass, but
// configuration writes are. A stalled receiver holds the result in the output
// register; the item after it is still taken, and its result waits until the
// output register is free.
// Depends on tt_pkg, tt_ifs, tt_ram, tt_apb_regs
`default_nettype none

module text_terminal_char_engine (
  input  logic                       clk,
  input  logic                       rst,
  tt_in_if.sink                      in_ch,
  tt_out_if.source                   out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tt_pkg::PADDR_W-1:0] paddr,
  input  logic [tt_pkg::PDATA_W-1:0] pwdata,
  output logic [tt_pkg::PDATA_W-1:0] prdata,
  output logic                       pready
);
  import tt_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [TOP_W-1:0]   top;
  logic [COL_W-1:0]   cursor;
  logic [CNT_W-1:0]   cnt;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [TOP_W-1:0]   fill_row;
  logic [TOP_W-1:0]   scan_row;
  logic               found;
  logic               pend_valid;
  logic [CNT_W-1:0]   pend_col;
  logic [WORD_W-1:0]  result_word;

  logic [ATTR_W-1:0]  text_attribute;
  logic [WORD_W-1:0]  blank;
  logic [TOP_W-1:0]   bot_row;
  logic               in_fire;
  logic               is_read;
  logic               in_range;
  logic               is_nl;
  logic               is_bs;
  logic               at_left;
  logic               at_right;
  logic               last_cnt;
  logic               scan_hit;
  logic               out_free;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [WORD_W-1:0]  mem_rdata;

  tt_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .text_attribute (text_attribute)
  );

  tt_ram #(
    .DEPTH (CELLS),
    .WIDTH (WORD_W)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign blank    = {text_attribute, CH_SPACE};
  assign bot_row  = row_dec(top);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign is_read  = (in_ch.action == ACT_READ);
  assign in_range = (int'(in_ch.read_row) < ROWS) && (int'(in_ch.read_col) < COLS);
  assign is_nl    = (in_ch.char_code == CH_NEWLINE);
  assign is_bs    = (in_ch.char_code == CH_BACKSPACE);
  assign at_left  = (cursor == '0);
  assign at_right = (cursor == COL_W'(COLS - 1));
  assign last_cnt = (cnt == CNT_W'(COLS - 1));
  assign scan_hit = (mem_rdata[CHAR_W-1:0] != CH_SPACE) && (mem_rdata[CHAR_W-1:0] != CH_NUL);
  assign out_free = !out_ch.valid || out_ch.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (is_read) begin
            state_next = in_range ? ST_READ : ST_DONE;
          end else if (is_nl) begin
            state_next = ST_FILL;
          end else if (is_bs) begin
            state_next = at_left ? ST_BSCAN : ST_DONE;
          end else begin
            state_next = at_right ? ST_FILL : ST_DONE;
          end
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_FILL, ST_BSCAN: begin
        if (last_cnt) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = blank;
    mem_raddr   = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = CELL_RESET;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (is_read) begin
            mem_raddr = cell_addr(phys_row(top, TOP_W'(in_ch.read_row)),
                                  CNT_W'(in_ch.read_col));
          end else if (is_bs) begin
            mem_we    = !at_left;
            mem_waddr = cell_addr(bot_row, CNT_W'(cursor) - 1'b1);
          end else if (!is_nl) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(bot_row, CNT_W'(cursor));
            mem_wdata = {text_attribute, in_ch.char_code};
          end
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(fill_row, cnt);
      end
      ST_BSCAN: begin
        // fill row and scan row differ, so the write never meets the read
        mem_we    = 1'b1;
        mem_waddr = cell_addr(fill_row, cnt);
        mem_raddr = cell_addr(scan_row, CNT_W'(COLS - 1) - cnt);
      end
      ST_READ, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      top          <= '0;
      cursor       <= '0;
      cnt          <= '0;
      found        <= 1'b0;
      pend_valid   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == ST_BSCAN) && !last_cnt;
      pend_col   <= CNT_W'(COLS - 1) - cnt;
      if ((state == ST_DONE) && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (in_fire) begin
            cnt         <= '0;
            found       <= 1'b0;
            result_word <= '0;
            if (!is_read) begin
              if (is_nl) begin
                cursor   <= '0;
                top      <= row_inc(top);
                fill_row <= top;
              end else if (is_bs) begin
                if (at_left) begin
                  cursor   <= '0;
                  top      <= row_dec(top);
                  fill_row <= row_dec(top);
                  scan_row <= row_dec(row_dec(top));
                end else begin
                  cursor <= cursor - 1'b1;
                end
              end else if (at_right) begin
                cursor   <= '0;
                top      <= row_inc(top);
                fill_row <= top;
              end else begin
                cursor <= cursor + 1'b1;
              end
            end
          end
        end
        ST_READ: result_word <= mem_rdata;
        ST_FILL: cnt <= cnt + 1'b1;
        ST_BSCAN: begin
          cnt <= cnt + 1'b1;
          if (pend_valid && !found && scan_hit) begin
            found <= 1'b1;
            if (pend_col == CNT_W'(COLS - 1)) begin
              cursor <= COL_W'(pend_col);
            end else begin
              cursor <= COL_W'(pend_col) + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_ch.cell_word     <= result_word;
            out_ch.cursor_column <= cursor;
            out_ch.cursor_line   <= ROW_W'(ROWS - 1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tt_checker.sv -----
// port-level checker for the text terminal character engine, bound to the top level
// depends on tt_pkg and text_terminal_char_engine
`default_nettype none

module tt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [tt_pkg::WORD_W-1:0] cell_word,
  input logic [tt_pkg::COL_W-1:0]  cursor_column,
  input logic [tt_pkg::ROW_W-1:0]  cursor_line
);
  import tt_pkg::*;

  // memory clearing pass blocks input right after reset
  a_clear_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during clearing pass");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cell_word) && $stable(cursor_column))
    else $error("result changed while stalled");

  a_line_bottom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_line == ROW_W'(ROWS - 1))
    else $error("cursor line not bottom row");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(cursor_column) < COLS)
    else $error("cursor column out of range");

endmodule

bind text_terminal_char_engine tt_checker u_tt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .cell_word     (out_ch.cell_word),
  .cursor_column (out_ch.cursor_column),
  .cursor_line   (out_ch.cursor_line)
);

`default_nettype wire
